[hw/rtl/pdpw_pkg.sv]
`timescale 1ns / 1ps

package pdpw_pkg;

  // Default size of one plane in bytes; the frame store holds one 32-bit word per byte.
  localparam int PLANE_BYTES_DEF = 65536;

  // The colour index has nine bits, and each index has two dither slots.
  localparam int DITHER_INDICES = 512;
  localparam int TABLE_SLOTS    = 2 * DITHER_INDICES;
  localparam int SLOT_W         = $clog2(TABLE_SLOTS);

  localparam logic [10:0] LINE_WIDTH_RESET = 11'd640;

  typedef enum logic [1:0] {
    ACT_PLOT = 2'd0,
    ACT_FILL = 2'd1,
    ACT_LOAD = 2'd2,
    ACT_READ = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_TAB0,
    ST_TAB1,
    ST_TAB2,
    ST_PIX_RD,
    ST_PIX_WR,
    ST_DONE
  } state_t;

  typedef struct packed {
    action_t     action;
    logic [9:0]  pos_x;
    logic [9:0]  pos_y;
    logic [9:0]  rect_width;
    logic [9:0]  rect_height;
    logic [23:0] colour_rgb;
    logic [9:0]  table_index;
    logic [3:0]  table_value;
  } req_t;

  typedef struct packed {
    logic [3:0] pixel_colour;
    logic       status;
  } rsp_t;

  // The top three bits of each byte form the index; the low byte lands highest.
  function automatic logic [8:0] colour_index(input logic [23:0] rgb);
    colour_index = {rgb[7:5], rgb[15:13], rgb[23:21]};
  endfunction

endpackage

[hw/rtl/planar_dithered_pixel_writer.sv]
`timescale 1ns / 1ps
// A table load goes straight to its response; a plot, read or fill first fetches its two
// dither colours (ST_TAB0 to ST_TAB2), then visits each pixel: ST_PIX_RD and ST_PIX_WR for a
// pixel inside the store, only ST_PIX_RD for one outside it. An empty fill skips the pixels.
// One transaction at a time; each pixel inside the store is read from the frame store, which
// has one registered read port, and for a plot or fill written back with the pixel merged in.
// Reset: a clearing pass writes zero to all PLANE_BYTES words, one a cycle, before the first
// transaction is accepted. Configuration writes are taken at all times.
module planar_dithered_pixel_writer
  import pdpw_pkg::*;
#(
  parameter int PLANE_BYTES = PLANE_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [10:0] cfg_data,
  input  logic        req_valid,
  output logic        req_ready,
  input  req_t        req,
  output logic        rsp_valid,
  input  logic        rsp_ready,
  output rsp_t        rsp
);

  localparam int AW = $clog2(PLANE_BYTES);

  state_t state, state_next;

  logic [10:0]   line_width;
  logic [AW-1:0] clr_addr;
  req_t          req_q;
  logic [21:0]   row_base;
  logic [10:0]   x_cur;
  logic [10:0]   y_cur;
  logic [9:0]    cols_left;
  logic [9:0]    rows_left;
  logic [3:0]    even_colour;
  logic [3:0]    odd_colour;
  logic [3:0]    colour_acc;
  logic          status_acc;

  logic [22:0]   pix_sum;
  logic [19:0]   pix_byte;
  logic          pix_in_range;
  logic          last_pix;
  logic          empty_fill;
  logic          accept;
  logic [2:0]    bit_pos;
  logic [3:0]    pix_colour;
  logic [3:0]    read_colour;
  logic [31:0]   mod_word;

  logic              tab_we;
  logic              tab_re;
  logic [SLOT_W-1:0] tab_raddr;
  logic [3:0]        tab_rdata;
  logic              fs_we;
  logic [AW-1:0]     fs_waddr;
  logic [31:0]       fs_wdata;
  logic              fs_re;
  logic [31:0]       fs_rdata;

  // Pixel address and its position within the byte.
  always_comb begin
    pix_sum      = {1'b0, row_base} + 23'(x_cur);
    pix_byte     = pix_sum[22:3];
    pix_in_range = pix_byte < 20'(PLANE_BYTES);
    bit_pos      = 3'd7 - x_cur[2:0];
    pix_colour   = (x_cur[0] ^ y_cur[0]) ? odd_colour : even_colour;
    last_pix     = (cols_left == 10'd1) && (rows_left == 10'd1);
    empty_fill   = (cols_left == 10'd0) || (rows_left == 10'd0);
    accept       = req_valid && req_ready;
  end

  // Merge the pixel into the four planes, and pick its colour out of them.
  always_comb begin
    mod_word = fs_rdata;
    for (int p = 0; p < 4; p++) begin
      mod_word[8 * p + int'(bit_pos)] = pix_colour[p];
      read_colour[p]                  = fs_rdata[8 * p + int'(bit_pos)];
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (clr_addr == AW'(PLANE_BYTES - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (req_valid) begin
          state_next = (req.action == ACT_LOAD) ? ST_DONE : ST_TAB0;
        end
      end
      ST_TAB0: state_next = ST_TAB1;
      ST_TAB1: state_next = ST_TAB2;
      ST_TAB2: state_next = empty_fill ? ST_DONE : ST_PIX_RD;
      ST_PIX_RD: begin
        if (pix_in_range) begin
          state_next = ST_PIX_WR;
        end else if (last_pix) begin
          state_next = ST_DONE;
        end
      end
      ST_PIX_WR: state_next = last_pix ? ST_DONE : ST_PIX_RD;
      ST_DONE: begin
        if (!rsp_valid || rsp_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Handshake and memory controls.
  always_comb begin
    cfg_ready = 1'b1;
    req_ready = (state == ST_IDLE);
    tab_we    = accept && (req.action == ACT_LOAD);
    tab_re    = (state == ST_TAB0) || (state == ST_TAB1);
    tab_raddr = {colour_index(req_q.colour_rgb), state == ST_TAB1};
    fs_re     = (state == ST_PIX_RD) && pix_in_range;
    if (state == ST_CLEAR) begin
      fs_we    = 1'b1;
      fs_waddr = clr_addr;
      fs_wdata = '0;
    end else begin
      fs_we    = (state == ST_PIX_WR) && (req_q.action != ACT_READ);
      fs_waddr = pix_byte[AW-1:0];
      fs_wdata = mod_word;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      clr_addr   <= '0;
      line_width <= LINE_WIDTH_RESET;
      rsp_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr_addr <= clr_addr + AW'(1);
      end
      if (cfg_valid) begin
        line_width <= cfg_data;
      end
      if (state == ST_DONE && (!rsp_valid || rsp_ready)) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Transaction datapath: walk the rectangle row by row, one pixel per visit.
  always_ff @(posedge clk) begin
    if (accept) begin
      req_q      <= req;
      x_cur      <= {1'b0, req.pos_x};
      y_cur      <= {1'b0, req.pos_y};
      cols_left  <= (req.action == ACT_FILL) ? req.rect_width : 10'd1;
      rows_left  <= (req.action == ACT_FILL) ? req.rect_height : 10'd1;
      colour_acc <= 4'd0;
      status_acc <= 1'b0;
    end
    if (state == ST_TAB0) begin
      row_base <= 22'(req_q.pos_y) * 22'(line_width);
    end
    if (state == ST_TAB1) begin
      even_colour <= tab_rdata;
    end
    if (state == ST_TAB2) begin
      odd_colour <= tab_rdata;
    end
    if (state == ST_PIX_RD && !pix_in_range) begin
      status_acc <= 1'b1;
    end
    if (state == ST_PIX_WR && req_q.action == ACT_READ) begin
      colour_acc <= read_colour;
    end
    if ((state == ST_PIX_RD && !pix_in_range) || state == ST_PIX_WR) begin
      if (cols_left == 10'd1) begin
        cols_left <= req_q.rect_width;
        rows_left <= rows_left - 10'd1;
        x_cur     <= {1'b0, req_q.pos_x};
        y_cur     <= y_cur + 11'd1;
        row_base  <= row_base + 22'(line_width);
      end else begin
        cols_left <= cols_left - 10'd1;
        x_cur     <= x_cur + 11'd1;
      end
    end
    if (state == ST_DONE && (!rsp_valid || rsp_ready)) begin
      rsp.pixel_colour <= colour_acc;
      rsp.status       <= status_acc;
    end
  end

  pdpw_ram #(
    .WIDTH (4),
    .DEPTH (TABLE_SLOTS)
  ) u_table (
    .clk   (clk),
    .we    (tab_we),
    .waddr (req.table_index[SLOT_W-1:0]),
    .wdata (req.table_value),
    .re    (tab_re),
    .raddr (tab_raddr),
    .rdata (tab_rdata)
  );

  pdpw_ram #(
    .WIDTH (32),
    .DEPTH (PLANE_BYTES)
  ) u_frame (
    .clk   (clk),
    .we    (fs_we),
    .waddr (fs_waddr),
    .wdata (fs_wdata),
    .re    (fs_re),
    .raddr (pix_byte[AW-1:0]),
    .rdata (fs_rdata)
  );

  // The frame store never reads and writes in the same cycle.
  a_no_overlap: assert property (@(posedge clk) disable iff (rst) !(fs_we && fs_re))
    else $error("frame store read and write in the same cycle");

  // Every pixel write follows the read of its word in the previous cycle.
  a_write_after_read: assert property (@(posedge clk) disable iff (rst)
    (fs_we && state != ST_CLEAR) |-> $past(fs_re))
    else $error("pixel write without a preceding read");

  // Writes stay inside the store.
  a_write_in_range: assert property (@(posedge clk) disable iff (rst)
    fs_we |-> (32'(fs_waddr) < 32'(PLANE_BYTES)))
    else $error("frame store write beyond the store");

  // No transaction is taken before the clearing pass has finished.
  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CLEAR) |=> !(req_valid && req_ready && $past(state) == ST_CLEAR
                             && $past(clr_addr) != AW'(PLANE_BYTES - 1)))
    else $error("transaction accepted during the clearing pass");

endmodule

[hw/rtl/pdpw_ram.sv]
`timescale 1ns / 1ps

module pdpw_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one read port; the read data is registered.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
